[rtl/core/tcpd_pkg.sv]
// tcpd_pkg: widths, codes and sideband types of the temperature to pwm duty pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package tcpd_pkg;

    localparam int RAW_W   = 20;
    localparam int CAL_W   = 16;
    localparam int WIN_W   = 15;
    localparam int TOP_W   = 16;
    localparam int TEMP_W  = 24;
    localparam int CFG_I_W = 3;

    // internal arithmetic widths
    localparam int A_W     = 18;
    localparam int D_W     = 17;
    localparam int P1_W    = A_W + CAL_W;
    localparam int DSQ_W   = 2 * D_W;
    localparam int DD_W    = 32;
    localparam int P2_W    = (DD_W - 12 + 1) + CAL_W;
    localparam int V_W     = 23;
    localparam int FINE_W  = 24;
    localparam int F5_W    = 27;
    localparam int T_W     = F5_W - 8;

    // divider widths
    localparam int NUM_W   = 31;
    localparam int DEN_W   = WIN_W;
    localparam int QUO_W   = TOP_W + 1;

    typedef enum logic [1:0] {
        FLAG_INSIDE = 2'd0,
        FLAG_BELOW  = 2'd1,
        FLAG_ABOVE  = 2'd2
    } t_flag;

    typedef enum logic [CFG_I_W-1:0] {
        CFG_CAL_T1     = 3'd0,
        CFG_CAL_T2     = 3'd1,
        CFG_CAL_T3     = 3'd2,
        CFG_WIN_LOW    = 3'd3,
        CFG_WIN_HIGH   = 3'd4,
        CFG_PERIOD_TOP = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [T_W-1:0]   temp;
        t_flag            flag;
        logic             inv;
        logic [TOP_W-1:0] inv_duty;
    } t_side;

endpackage

`default_nettype wire

[rtl/core/tcpd_div.sv]
// tcpd_div: pipelined restoring divider, one quotient bit per stage, sideband carried along
// depends on tcpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcpd_div
    import tcpd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire t_side            i_side,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [QUO_W-1:0]      o_quo,
    output t_side                 o_side
);

    localparam int HI_W = NUM_W - QUO_W;

    logic             r_vld  [QUO_W];
    logic [DEN_W-1:0] r_rem  [QUO_W];
    logic [QUO_W-1:0] r_lq   [QUO_W];
    logic [DEN_W-1:0] r_den  [QUO_W];
    t_side            r_side [QUO_W];

    logic             w_rdy   [QUO_W];
    logic             w_src_v [QUO_W];
    logic [DEN_W-1:0] w_src_r [QUO_W];
    logic [QUO_W-1:0] w_src_q [QUO_W];
    logic [DEN_W-1:0] w_src_d [QUO_W];
    t_side            w_src_s [QUO_W];
    logic [DEN_W-1:0] n_rem   [QUO_W];
    logic [QUO_W-1:0] n_lq    [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W:0] w_trial;
        logic [DEN_W:0] w_diff;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign w_src_v[k] = i_valid;
            assign w_src_r[k] = {{(DEN_W-HI_W){1'b0}}, i_num[NUM_W-1:QUO_W]};
            assign w_src_q[k] = i_num[QUO_W-1:0];
            assign w_src_d[k] = i_den;
            assign w_src_s[k] = i_side;
        end else begin : g_next
            assign w_src_v[k] = r_vld[k-1];
            assign w_src_r[k] = r_rem[k-1];
            assign w_src_q[k] = r_lq[k-1];
            assign w_src_d[k] = r_den[k-1];
            assign w_src_s[k] = r_side[k-1];
        end

        if (k == QUO_W - 1) begin : g_last
            assign w_rdy[k] = !r_vld[k] || i_ready;
        end else begin : g_mid
            assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end

        // trial subtract of the divisor from the shifted partial remainder
        assign w_trial  = {w_src_r[k], w_src_q[k][QUO_W-1]};
        assign w_diff   = w_trial - {1'b0, w_src_d[k]};
        assign w_ge     = w_trial >= {1'b0, w_src_d[k]};
        assign n_rem[k] = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        assign n_lq[k]  = {w_src_q[k][QUO_W-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= w_src_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_src_v[k]) begin
                r_rem[k]  <= n_rem[k];
                r_lq[k]   <= n_lq[k];
                r_den[k]  <= w_src_d[k];
                r_side[k] <= w_src_s[k];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_lq[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

`default_nettype wire

[rtl/core/temp_compensate_to_pwm_duty.sv]
// Raw 20-bit temperature reading in, compensated temperature in hundredths of a degree,
// pwm compare value and window flag out. Fully pipelined: one reading is taken every
// cycle unless the output stalls; each result passes through six arithmetic stages,
// a 17-stage divider producing one quotient bit per stage and one output register, with
// stalls on the output absorbed stage by stage so gaps fill up. Calibration and window
// registers are read live by the pipeline and must only be written while it is empty.
// Depends on tcpd_pkg and tcpd_div.
`timescale 1ns / 1ps
`default_nettype none

module temp_compensate_to_pwm_duty
    import tcpd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [RAW_W-1:0]   i_raw_reading,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [TEMP_W-1:0] o_temp_centi,
    output logic [TOP_W-1:0]        o_duty_compare,
    output logic [1:0]              o_range_flag,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CFG_I_W-1:0] i_cfg_index,
    input  wire logic [CAL_W-1:0]   i_cfg_data
);

    // configuration registers
    logic [CAL_W-1:0]        r_cal_t1;
    logic signed [CAL_W-1:0] r_cal_t2;
    logic signed [CAL_W-1:0] r_cal_t3;
    logic signed [WIN_W-1:0] r_win_lo;
    logic signed [WIN_W-1:0] r_win_hi;
    logic [TOP_W-1:0]        r_top;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t1 <= 16'd27504;
            r_cal_t2 <= 16'sd26435;
            r_cal_t3 <= -16'sd1000;
            r_win_lo <= 15'sd2000;
            r_win_hi <= 15'sd4000;
            r_top    <= 16'd999;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CAL_T1:     r_cal_t1 <= i_cfg_data;
                CFG_CAL_T2:     r_cal_t2 <= i_cfg_data;
                CFG_CAL_T3:     r_cal_t3 <= i_cfg_data;
                CFG_WIN_LOW:    r_win_lo <= i_cfg_data[WIN_W-1:0];
                CFG_WIN_HIGH:   r_win_hi <= i_cfg_data[WIN_W-1:0];
                CFG_PERIOD_TOP: r_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake
    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_vld_e, r_vld_f, r_vld_g;
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d, w_rdy_e, w_rdy_f, w_rdy_g;
    logic w_div_rdy, w_div_vld;

    assign w_rdy_g    = !r_vld_g || i_out_ready;
    assign w_rdy_f    = !r_vld_f || w_div_rdy;
    assign w_rdy_e    = !r_vld_e || w_rdy_f;
    assign w_rdy_d    = !r_vld_d || w_rdy_e;
    assign w_rdy_c    = !r_vld_c || w_rdy_d;
    assign w_rdy_b    = !r_vld_b || w_rdy_c;
    assign w_rdy_a    = !r_vld_a || w_rdy_b;
    assign o_in_ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
            r_vld_f <= 1'b0;
            r_vld_g <= 1'b0;
        end else begin
            if (w_rdy_a) r_vld_a <= i_in_valid;
            if (w_rdy_b) r_vld_b <= r_vld_a;
            if (w_rdy_c) r_vld_c <= r_vld_b;
            if (w_rdy_d) r_vld_d <= r_vld_c;
            if (w_rdy_e) r_vld_e <= r_vld_d;
            if (w_rdy_f) r_vld_f <= r_vld_e;
            if (w_rdy_g) r_vld_g <= w_div_vld;
        end
    end

    // stage a: offsets from calibration word one
    logic signed [A_W-1:0] n_a, r_a;
    logic signed [D_W-1:0] n_d, r_d;

    assign n_a = $signed({1'b0, i_raw_reading[RAW_W-1:3]}) - $signed({1'b0, r_cal_t1, 1'b0});
    assign n_d = $signed({1'b0, i_raw_reading[RAW_W-1:4]}) - $signed({1'b0, r_cal_t1});

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_in_valid) begin
            r_a <= n_a;
            r_d <= n_d;
        end
    end

    // stage b: linear product and square
    logic signed [P1_W-1:0]  n_p1, r_p1;
    logic signed [DSQ_W-1:0] w_dsq;
    logic [DD_W-1:0]         r_dd;

    assign n_p1  = r_a * r_cal_t2;
    assign w_dsq = r_d * r_d;

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_vld_a) begin
            r_p1 <= n_p1;
            r_dd <= w_dsq[DD_W-1:0];
        end
    end

    // stage c: var1 and quadratic product
    logic signed [V_W-1:0]  r_var1;
    logic signed [P2_W-1:0] n_p2, r_p2;

    assign n_p2 = $signed({1'b0, r_dd[DD_W-1:12]}) * r_cal_t3;

    always_ff @(posedge i_clk) begin
        if (w_rdy_c && r_vld_b) begin
            r_var1 <= r_p1[P1_W-1:11];
            r_p2   <= n_p2;
        end
    end

    // stage d: fine value and temperature
    logic signed [V_W-1:0]    w_var2;
    logic signed [FINE_W-1:0] w_fine;
    logic signed [F5_W-1:0]   w_fine_x;
    logic signed [F5_W-1:0]   w_f5;
    logic signed [T_W-1:0]    r_t;

    assign w_var2   = r_p2[P2_W-1:14];
    assign w_fine   = $signed({r_var1[V_W-1], r_var1}) + $signed({w_var2[V_W-1], w_var2});
    assign w_fine_x = {{(F5_W-FINE_W){w_fine[FINE_W-1]}}, w_fine};
    assign w_f5     = (w_fine_x <<< 2) + w_fine_x + F5_W'(128);

    always_ff @(posedge i_clk) begin
        if (w_rdy_d && r_vld_c) begin
            r_t <= w_f5[F5_W-1:8];
        end
    end

    // stage e: window compare and clamp
    logic signed [T_W-1:0]   w_lo, w_hi, w_off;
    logic signed [WIN_W:0]   w_span;
    logic                    w_inv, w_below, w_above_lo, w_above_hi;
    logic [DEN_W-1:0]        n_diff, r_diff, r_den_e;
    t_side                   n_side_e, r_side_e;

    assign w_lo       = {{(T_W-WIN_W){r_win_lo[WIN_W-1]}}, r_win_lo};
    assign w_hi       = {{(T_W-WIN_W){r_win_hi[WIN_W-1]}}, r_win_hi};
    assign w_span     = $signed({r_win_hi[WIN_W-1], r_win_hi})
                      - $signed({r_win_lo[WIN_W-1], r_win_lo});
    assign w_off      = r_t - w_lo;
    assign w_inv      = r_win_hi <= r_win_lo;
    assign w_below    = r_t < w_lo;
    assign w_above_lo = r_t > w_lo;
    assign w_above_hi = r_t > w_hi;

    always_comb begin
        n_side_e.temp     = r_t;
        n_side_e.inv      = w_inv;
        n_side_e.inv_duty = w_above_lo ? r_top : '0;
        n_diff            = w_off[DEN_W-1:0];
        if (w_below) begin
            n_side_e.flag = FLAG_BELOW;
            n_diff        = '0;
        end else if (w_inv ? w_above_lo : w_above_hi) begin
            n_side_e.flag = FLAG_ABOVE;
            n_diff        = w_span[DEN_W-1:0];
        end else begin
            n_side_e.flag = FLAG_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_e && r_vld_d) begin
            r_diff   <= n_diff;
            r_den_e  <= w_span[DEN_W-1:0];
            r_side_e <= n_side_e;
        end
    end

    // stage f: scale by period
    logic [TOP_W:0]       w_top1;
    logic [NUM_W:0]       w_prod;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den_f;
    t_side                r_side_f;

    assign w_top1 = {1'b0, r_top} + 1'b1;
    assign w_prod = r_diff * w_top1;

    always_ff @(posedge i_clk) begin
        if (w_rdy_f && r_vld_e) begin
            r_num    <= w_prod[NUM_W-1:0];
            r_den_f  <= r_den_e;
            r_side_f <= r_side_e;
        end
    end

    logic [QUO_W-1:0] w_quo;
    t_side            w_side_q;

    tcpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld_f),
        .o_ready (w_div_rdy),
        .i_num   (r_num),
        .i_den   (r_den_f),
        .i_side  (r_side_f),
        .o_valid (w_div_vld),
        .i_ready (w_rdy_g),
        .o_quo   (w_quo),
        .o_side  (w_side_q)
    );

    // output register
    logic [TOP_W-1:0]        n_duty, r_duty;
    logic signed [TEMP_W-1:0] r_temp;
    t_flag                   r_flag;

    always_comb begin
        if (w_side_q.inv) begin
            n_duty = w_side_q.inv_duty;
        end else if (w_quo > {1'b0, r_top}) begin
            n_duty = r_top;
        end else begin
            n_duty = w_quo[TOP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_g && w_div_vld) begin
            r_temp <= {{(TEMP_W-T_W){w_side_q.temp[T_W-1]}}, w_side_q.temp};
            r_duty <= n_duty;
            r_flag <= w_side_q.flag;
        end
    end

    assign o_out_valid    = r_vld_g;
    assign o_temp_centi   = r_temp;
    assign o_duty_compare = r_duty;
    assign o_range_flag   = r_flag;

endmodule

`default_nettype wire

[rtl/core/tcpd_chk.sv]
// tcpd_chk: port-level checks on temp_compensate_to_pwm_duty, bound to the top level
// depends on tcpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcpd_chk
    import tcpd_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [TEMP_W-1:0]  o_temp_centi,
    input wire logic [TOP_W-1:0]   o_duty_compare,
    input wire logic [1:0]         o_range_flag
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an empty output stage means the whole pipe can take a transfer
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_temp_centi)
            && $stable(o_duty_compare) && $stable(o_range_flag))
        else $error("stalled result changed");

    // compensated temperature never reaches beyond 19 significant bits
    a_temp_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones(o_temp_centi[TEMP_W-1:T_W-1]) == 0
            || $countones(o_temp_centi[TEMP_W-1:T_W-1]) == TEMP_W - T_W + 1))
        else $error("temperature out of span");

    a_flag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_range_flag != 2'd3)
        else $error("bad range flag");

endmodule

bind temp_compensate_to_pwm_duty tcpd_chk u_tcpd_chk (.*);

`default_nettype wire
